// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by ietp_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ietp_pkg.sv -----
// ----------------------------------------------------------------------------
// ietp_pkg
// shared types and constants of the input event to pointer message block
// ----------------------------------------------------------------------------
package ietp_pkg;

   // event types
   localparam logic [4:0] EV_SYN = 5'd0;
   localparam logic [4:0] EV_KEY = 5'd1;
   localparam logic [4:0] EV_REL = 5'd2;
   localparam logic [4:0] EV_ABS = 5'd3;

   // event codes
   localparam logic [9:0] CODE_X           = 10'h000;
   localparam logic [9:0] CODE_Y           = 10'h001;
   localparam logic [9:0] CODE_WHEEL       = 10'h008;
   localparam logic [9:0] CODE_HIRES_WHEEL = 10'h00b;
   localparam logic [9:0] CODE_SYN_REPORT  = 10'h000;
   localparam logic [9:0] BUTTON_BASE      = 10'h110;

   localparam logic [15:0] GAIN_RESET = 16'd350;
   localparam int unsigned DETENT     = 120;

   // divide by 15 through a reciprocal, exact for dividends below 2^29
   localparam logic [31:0] DIV15_MAGIC = 32'h8888_8889;
   localparam int unsigned DIV15_SHIFT = 35;

   typedef logic signed [47:0] ietp_cursor_type;

   localparam ietp_cursor_type CURSOR_HOME = 48'sd32768;
   localparam ietp_cursor_type CURSOR_MAX  = 48'sh7FFF_FFFF_FFFF;
   localparam ietp_cursor_type CURSOR_MIN  = 48'sh8000_0000_0000;
   localparam logic [15:0]     SCREEN_MAX  = 16'hFFFF;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_REL_X,
      OP_REL_Y,
      OP_ABS_X,
      OP_ABS_Y,
      OP_WHEEL,
      OP_HIRES,
      OP_KEY,
      OP_SYNC
   } ietp_op_type;

   typedef enum logic [2:0] {
      KIND_KEY_UP   = 3'd0,
      KIND_KEY_DOWN = 3'd1,
      KIND_BUTTON   = 3'd2,
      KIND_WHEEL    = 3'd3,
      KIND_MOVE     = 3'd4
   } ietp_kind_type;

   // decoded event handed from the front end to the tracking stage
   typedef struct packed {
      ietp_op_type        op;
      logic [9:0]         code;
      logic signed [31:0] value;
      logic signed [48:0] delta;   // value times gain
      logic [24:0]        wq;      // |value| / 120
      logic               wneg;    // value negative
      logic [6:0]         wlow;    // low bits of |value|
   } ietp_opnd_type;

endpackage

// ----- rtl/input_event_to_pointer_message.sv -----
// ----------------------------------------------------------------------------
// input_event_to_pointer_message
// turns input events into key, button, wheel and pointer move messages
// ----------------------------------------------------------------------------
// usage
//   req_*  : one event word per handshake (type, code, signed value)
//   rsp_*  : zero or one message word per event (kind, first, second value)
//   csr_*  : motion gain, written with csr_wr_en, no wait, takes effect for
//            events that reach the multiply stage afterwards
// timing
//   three register stages: input register, decode/multiply register,
//   state update into the result register; an event's message shows on
//   rsp_valid once it has passed all three; one event per cycle sustained
//   while the receiver keeps up; the cursor and wheel state live in the
//   last stage only, so back-to-back events see each other's updates
// reset
//   synchronous, active high; cursor goes to 32768/32768, no move pending,
//   wheel residue zero, gain 350, all stages empty
// stalls
//   while rsp_ready is low the result holds and the stages behind it fill;
//   req_ready drops only once all stages hold a word
// ----------------------------------------------------------------------------
module input_event_to_pointer_message import ietp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // event channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [4:0]           req_func,
   input  logic [9:0]           req_event_code,
   input  logic signed [31:0]   req_event_value,
   // message channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_msg_kind,
   output logic signed [31:0]   rsp_first_value,
   output logic signed [31:0]   rsp_second_value,
   // gain register
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data
);

   // decoded event between the front end and the state stage
   logic            opnd_valid;
   ietp_opnd_type   opnd;
   logic            core_ready;

   // front end: input register, decode, gain product, /120 quotient
   ietp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_event_code  (req_event_code),
      .req_event_value (req_event_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .opnd_valid      (opnd_valid),
      .opnd            (opnd),
      .core_ready      (core_ready)
   );

   // state stage: cursor, pending move, wheel residue, result register
   ietp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .opnd_valid       (opnd_valid),
      .opnd             (opnd),
      .core_ready       (core_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_msg_kind     (rsp_msg_kind),
      .rsp_first_value  (rsp_first_value),
      .rsp_second_value (rsp_second_value)
   );

endmodule

// ----- rtl/ietp_front.sv -----
// ----------------------------------------------------------------------------
// ietp_front
// input register, event decode, gain multiply and detent quotient
// ----------------------------------------------------------------------------
module ietp_front import ietp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [4:0]           req_func,
   input  logic [9:0]           req_event_code,
   input  logic signed [31:0]   req_event_value,
   input  logic                 csr_wr_en,
   input  logic [15:0]          csr_wr_data,
   output logic                 opnd_valid,
   output ietp_opnd_type        opnd,
   input  logic                 core_ready
);

   logic                 s1_valid_ff, s1_valid_in;
   logic [4:0]           s1_func_ff;
   logic [9:0]           s1_code_ff;
   logic signed [31:0]   s1_value_ff;
   logic                 s2_valid_ff, s2_valid_in;
   ietp_opnd_type        s2_opnd_ff, s2_opnd_in;
   logic [15:0]          gain_ff, gain_in;

   logic                 s2_free;
   logic                 s1_go;
   logic                 req_take;
   logic [31:0]          mag;
   logic [60:0]          recip;
   logic signed [48:0]   delta_mul;
   ietp_op_type          op_dec;

   assign s2_free   = !s2_valid_ff || core_ready;
   assign s1_go     = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in = req_take ? 1'b1 : (s1_valid_ff && !s1_go);
   assign s2_valid_in = s1_go ? 1'b1 : (s2_valid_ff && !core_ready);
   assign gain_in     = csr_wr_en ? csr_wr_data : gain_ff;

   always_comb begin
      op_dec = OP_NONE;
      case (s1_func_ff)
         EV_REL: begin
            case (s1_code_ff)
               CODE_X:           op_dec = OP_REL_X;
               CODE_Y:           op_dec = OP_REL_Y;
               CODE_WHEEL:       op_dec = OP_WHEEL;
               CODE_HIRES_WHEEL: op_dec = OP_HIRES;
               default:          op_dec = OP_NONE;
            endcase
         end
         EV_ABS: begin
            case (s1_code_ff)
               CODE_X:  op_dec = OP_ABS_X;
               CODE_Y:  op_dec = OP_ABS_Y;
               default: op_dec = OP_NONE;
            endcase
         end
         EV_KEY: op_dec = OP_KEY;
         EV_SYN: op_dec = (s1_code_ff == CODE_SYN_REPORT) ? OP_SYNC : OP_NONE;
         default: op_dec = OP_NONE;
      endcase
   end

   // magnitude, then /120 as (>>3) and a reciprocal multiply for /15
   assign mag       = s1_value_ff[31] ? (~s1_value_ff + 32'd1) : s1_value_ff;
   assign recip     = 61'(mag[31:3]) * 61'(DIV15_MAGIC);
   assign delta_mul = $signed(s1_value_ff) * $signed({1'b0, gain_ff});

   always_comb begin
      s2_opnd_in.op    = op_dec;
      s2_opnd_in.code  = s1_code_ff;
      s2_opnd_in.value = s1_value_ff;
      s2_opnd_in.delta = delta_mul;
      s2_opnd_in.wq    = recip[DIV15_SHIFT +: 25];
      s2_opnd_in.wneg  = s1_value_ff[31];
      s2_opnd_in.wlow  = mag[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         gain_ff     <= GAIN_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         gain_ff     <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff  <= req_func;
         s1_code_ff  <= req_event_code;
         s1_value_ff <= req_event_value;
      end
      if (s1_go) begin
         s2_opnd_ff <= s2_opnd_in;
      end
   end

   assign opnd_valid = s2_valid_ff;
   assign opnd       = s2_opnd_ff;

endmodule

// ----- rtl/ietp_core.sv -----
// ----------------------------------------------------------------------------
// ietp_core
// cursor and wheel state update, result register
// ----------------------------------------------------------------------------
module ietp_core import ietp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 opnd_valid,
   input  ietp_opnd_type        opnd,
   output logic                 core_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_msg_kind,
   output logic signed [31:0]   rsp_first_value,
   output logic signed [31:0]   rsp_second_value
);

   ietp_cursor_type      cursor_x_ff, cursor_x_in;
   ietp_cursor_type      cursor_y_ff, cursor_y_in;
   logic                 pending_ff, pending_in;
   logic signed [7:0]    residue_ff, residue_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ietp_kind_type        rsp_kind_ff, rsp_kind_in;
   logic signed [31:0]   rsp_first_ff, rsp_first_in;
   logic signed [31:0]   rsp_second_ff, rsp_second_in;

   logic                 take;
   logic                 has_result;
   logic signed [49:0]   sum_x, sum_y;
   logic [15:0]          clamp_x, clamp_y;

   logic [6:0]           wh_ra;
   logic signed [26:0]   wh_qext, wh_qf, wh_qf2, wh_steps;
   logic [7:0]           wh_rf, wh_rf2;
   logic signed [8:0]    wh_x;
   logic signed [7:0]    wh_res;

   function automatic ietp_cursor_type sat48(input logic signed [49:0] s);
      if (s[49:47] == 3'b000 || s[49:47] == 3'b111) begin
         return s[47:0];
      end else if (s[49]) begin
         return CURSOR_MIN;
      end else begin
         return CURSOR_MAX;
      end
   endfunction

   function automatic logic [15:0] clamp16(input ietp_cursor_type v);
      if (v[47]) begin
         return 16'h0000;
      end else if (|v[46:16]) begin
         return SCREEN_MAX;
      end else begin
         return v[15:0];
      end
   endfunction

   assign core_ready = !rsp_valid_ff || rsp_ready;
   assign take       = opnd_valid && core_ready;

   assign sum_x   = 50'(cursor_x_ff) + 50'($signed(opnd.delta));
   assign sum_y   = 50'(cursor_y_ff) + 50'($signed(opnd.delta));
   assign clamp_x = clamp16(cursor_x_ff);
   assign clamp_y = clamp16(cursor_y_ff);

   // remainder of |value| / 120 mod 128: |value| + 8 * quotient
   assign wh_ra   = opnd.wlow + {opnd.wq[3:0], 3'b000};
   assign wh_qext = $signed({2'b00, opnd.wq});

   // floor quotient and remainder of the event value alone
   always_comb begin
      if (opnd.wneg && wh_ra != 7'd0) begin
         wh_qf = ~wh_qext;
         wh_rf = 8'(DETENT) - {1'b0, wh_ra};
      end else if (opnd.wneg) begin
         wh_qf = -wh_qext;
         wh_rf = 8'd0;
      end else begin
         wh_qf = wh_qext;
         wh_rf = {1'b0, wh_ra};
      end
   end

   // fold in the kept residue, then back to truncation toward zero
   assign wh_x = $signed({1'b0, wh_rf}) + $signed({residue_ff[7], residue_ff});

   always_comb begin
      if (wh_x[8]) begin
         wh_qf2 = wh_qf - 27'sd1;
         wh_rf2 = 8'(wh_x + 9'sd120);
      end else if (wh_x >= 9'sd120) begin
         wh_qf2 = wh_qf + 27'sd1;
         wh_rf2 = 8'(wh_x - 9'sd120);
      end else begin
         wh_qf2 = wh_qf;
         wh_rf2 = 8'(wh_x);
      end
      if (wh_qf2[26] && wh_rf2 != 8'd0) begin
         wh_steps = wh_qf2 + 27'sd1;
         wh_res   = $signed(wh_rf2 - 8'(DETENT));
      end else begin
         wh_steps = wh_qf2;
         wh_res   = $signed(wh_rf2);
      end
   end

   always_comb begin
      cursor_x_in   = cursor_x_ff;
      cursor_y_in   = cursor_y_ff;
      pending_in    = pending_ff;
      residue_in    = residue_ff;
      has_result    = 1'b0;
      rsp_kind_in   = KIND_KEY_UP;
      rsp_first_in  = 32'sd0;
      rsp_second_in = 32'sd0;
      case (opnd.op)
         OP_REL_X: begin
            cursor_x_in = sat48(sum_x);
            pending_in  = 1'b1;
         end
         OP_REL_Y: begin
            cursor_y_in = sat48(sum_y);
            pending_in  = 1'b1;
         end
         OP_ABS_X: begin
            cursor_x_in = 48'($signed(opnd.value));
            pending_in  = 1'b1;
         end
         OP_ABS_Y: begin
            cursor_y_in = 48'($signed(opnd.value));
            pending_in  = 1'b1;
         end
         OP_WHEEL: begin
            has_result   = (opnd.value != 32'sd0);
            rsp_kind_in  = KIND_WHEEL;
            rsp_first_in = opnd.value;
         end
         OP_HIRES: begin
            residue_in   = wh_res;
            has_result   = (wh_steps != 27'sd0);
            rsp_kind_in  = KIND_WHEEL;
            rsp_first_in = 32'(wh_steps);
         end
         OP_KEY: begin
            has_result = 1'b1;
            if (opnd.code >= BUTTON_BASE) begin
               rsp_kind_in = KIND_BUTTON;
            end else if (opnd.value == 32'sd0) begin
               rsp_kind_in = KIND_KEY_UP;
            end else begin
               rsp_kind_in = KIND_KEY_DOWN;
            end
            rsp_first_in  = $signed({22'd0, opnd.code});
            rsp_second_in = opnd.value;
         end
         OP_SYNC: begin
            if (pending_ff) begin
               cursor_x_in   = $signed({32'd0, clamp_x});
               cursor_y_in   = $signed({32'd0, clamp_y});
               pending_in    = 1'b0;
               has_result    = 1'b1;
               rsp_kind_in   = KIND_MOVE;
               rsp_first_in  = $signed({16'd0, clamp_x});
               rsp_second_in = $signed({16'd0, clamp_y});
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = take ? has_result : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= CURSOR_HOME;
         cursor_y_ff  <= CURSOR_HOME;
         pending_ff   <= 1'b0;
         residue_ff   <= 8'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            cursor_x_ff <= cursor_x_in;
            cursor_y_ff <= cursor_y_in;
            pending_ff  <= pending_in;
            residue_ff  <= residue_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && has_result) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_first_ff  <= rsp_first_in;
         rsp_second_ff <= rsp_second_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_msg_kind     = rsp_kind_ff;
   assign rsp_first_value  = rsp_first_ff;
   assign rsp_second_value = rsp_second_ff;

endmodule

// ----- rtl/ietp_checker.sv -----
// ----------------------------------------------------------------------------
// ietp_checker
// port-level checks on the pointer message block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ietp_checker import ietp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [2:0]           rsp_msg_kind,
   input  logic signed [31:0]   rsp_first_value,
   input  logic signed [31:0]   rsp_second_value
);

   // a stalled message holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_msg_kind) && $stable(rsp_first_value) && $stable(rsp_second_value), "stalled message changed")

   // backpressure only comes from a stalled receiver
   `ASSERT_IMPLY(a_ready_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready, "event channel throttled without receiver stall")

   // move coordinates lie on the screen
   `ASSERT_IMPLY(a_move_range, clock, reset, rsp_valid && rsp_msg_kind == KIND_MOVE, rsp_first_value[31:16] == 16'h0000 && rsp_second_value[31:16] == 16'h0000, "move outside screen range")

   // wheel messages carry nonzero steps and a zero second value
   `ASSERT_IMPLY(a_wheel_form, clock, reset, rsp_valid && rsp_msg_kind == KIND_WHEEL, rsp_first_value != 32'sd0 && rsp_second_value == 32'sd0, "malformed wheel message")

   // button codes come from the button range
   `ASSERT_IMPLY(a_button_code, clock, reset, rsp_valid && rsp_msg_kind == KIND_BUTTON, rsp_first_value[31:10] == 22'd0 && rsp_first_value[9:0] >= BUTTON_BASE, "button code below button base")

endmodule

bind input_event_to_pointer_message ietp_checker u_ietp_checker (.*);
